// File: design/assert_macros.svh
// assertion helpers used by the frame ring fifo core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FRF_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/frf_pkg.sv
// shared types and constants for the frame ring fifo
// no dependencies
package frf_pkg;

    localparam int SLOTS_DEF          = 16;
    localparam int SLOT_BYTES_MAX_DEF = 2048;

    // configuration port
    localparam int          CFG_W           = 12;
    localparam int          PADDR_W         = 3;
    localparam logic [11:0] SLOT_BYTES_RST  = 12'd2048;
    localparam logic [0:0]  REG_SLOT_BYTES  = 1'b0;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_TRUNC    = 2'd2,
        STAT_UNDERRUN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } fsm_t;

    // memory strobes from the controller
    typedef struct packed {
        logic store_we;
        logic len_we;
        logic rd_en;
    } mem_ctl_t;

    // one result word
    typedef struct packed {
        logic [7:0]  data_out;
        logic        last_out;
        status_t     status;
        logic [3:0]  frames_held;
        logic [31:0] overrun_count;
        logic [31:0] underrun_count;
    } rsp_t;

endpackage

// File: design/frf_if.sv
// valid/ready channels for request and result words
// no dependencies
interface frf_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_in;

    modport source (output valid, output req_type, output data_byte, output last_in,
                    input ready);
    modport sink (input valid, input req_type, input data_byte, input last_in,
                  output ready);
endinterface

interface frf_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_out;
    logic        last_out;
    logic [1:0]  status;
    logic [3:0]  frames_held;
    logic [31:0] overrun_count;
    logic [31:0] underrun_count;

    modport source (output valid, output data_out, output last_out, output status,
                    output frames_held, output overrun_count, output underrun_count,
                    input ready);
    modport sink (input valid, input data_out, input last_out, input status,
                  input frames_held, input overrun_count, input underrun_count,
                  output ready);
endinterface

// File: design/frf_regs.sv
// apb-style configuration register holding the slot byte limit
// depends on frf_pkg
module frf_regs
    import frf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [CFG_W-1:0]   slot_bytes
);

    logic [CFG_W-1:0] slot_bytes_reg;
    logic             wr_hit;

    // write strobe on the access phase
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SLOT_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bytes_reg <= SLOT_BYTES_RST;
        end
        else if (wr_hit)
        begin
            slot_bytes_reg <= pwdata[CFG_W-1:0];
        end
    end

    // read back
    assign prdata = (paddr[PADDR_W-1:2] == REG_SLOT_BYTES)
                  ? {{(32-CFG_W){1'b0}}, slot_bytes_reg} : 32'd0;

    assign slot_bytes = slot_bytes_reg;

endmodule

// File: design/frf_mem.sv
// frame byte store and per-slot length table, registered reads
// depends on frf_pkg
module frf_mem
    import frf_pkg::*;
#(
    parameter int SLOTS          = SLOTS_DEF,
    parameter int SLOT_BYTES_MAX = SLOT_BYTES_MAX_DEF
)
(
    input  logic                                     clk,
    input  mem_ctl_t                                 ctl,
    input  logic [$clog2(SLOTS*SLOT_BYTES_MAX)-1:0] store_waddr,
    input  logic [7:0]                               store_wdata,
    input  logic [$clog2(SLOTS*SLOT_BYTES_MAX)-1:0] store_raddr,
    input  logic [$clog2(SLOTS)-1:0]                 len_waddr,
    input  logic [$clog2(SLOT_BYTES_MAX+1)-1:0]      len_wdata,
    input  logic [$clog2(SLOTS)-1:0]                 len_raddr,
    output logic [7:0]                               rd_byte,
    output logic [$clog2(SLOT_BYTES_MAX+1)-1:0]      rd_len
);

    localparam int DEPTH  = SLOTS * SLOT_BYTES_MAX;
    localparam int POS_W  = $clog2(SLOT_BYTES_MAX + 1);

    logic [7:0]       store_mem [DEPTH];
    logic [POS_W-1:0] len_mem   [SLOTS];
    logic [7:0]       rd_byte_reg;
    logic [POS_W-1:0] rd_len_reg;

    // frame bytes
    always_ff @(posedge clk)
    begin
        if (ctl.store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_byte_reg <= store_mem[store_raddr];
        end
    end

    // stored frame lengths
    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_len_reg <= len_mem[len_raddr];
        end
    end

    assign rd_byte = rd_byte_reg;
    assign rd_len  = rd_len_reg;

endmodule

// File: design/frame_ring_fifo_core.sv
// frame ring fifo: a stored-byte pull adds S_READ (registered read of the byte store)
// one word in flight; a new word is taken as soon as the previous result is registered
// results sit in an output register; while it is held the next word's result is parked
// and further words wait until the output register frees
// reset clears pointers, counters and handshake state; byte and length memories
// are not cleared and only completed frames are ever read
module frame_ring_fifo_core
    import frf_pkg::*;
#(
    parameter int SLOTS          = SLOTS_DEF,
    parameter int SLOT_BYTES_MAX = SLOT_BYTES_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    frf_req_if.sink            req,
    frf_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "assert_macros.svh"

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(SLOT_BYTES_MAX + 1);
    localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES_MAX);
    localparam int HW     = (SLOT_W + 1 > 4) ? SLOT_W + 1 : 4;

    logic [CFG_W-1:0]  slot_bytes;
    logic [12:0]       cfg_ext;
    logic [12:0]       lim_wide;
    logic [POS_W-1:0]  limit;

    fsm_t              state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next, head_inc;
    logic [SLOT_W-1:0] tail_reg, tail_next, tail_inc;
    logic [POS_W-1:0]  wpos_reg, wpos_next, wpos_inc;
    logic [POS_W-1:0]  rpos_reg, rpos_next, rpos_inc;
    logic [POS_W-1:0]  len_val;
    logic              drop_reg, drop_next;
    logic [31:0]       ovr_reg, ovr_next;
    logic [31:0]       und_reg, und_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              pend_reg, pend_next;

    rsp_t              res;
    logic              res_ready;
    logic              accept;
    logic              out_free;
    logic              ring_empty;
    logic              pull_hit;
    logic [SLOT_W:0]   held_w;
    logic [HW-1:0]     held_x;

    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [7:0]        rd_byte;
    logic [POS_W-1:0]  rd_len;

    frf_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .slot_bytes (slot_bytes)
    );

    frf_mem #(
        .SLOTS          (SLOTS),
        .SLOT_BYTES_MAX (SLOT_BYTES_MAX)
    ) u_mem (
        .clk         (clk),
        .ctl         (mem_ctl),
        .store_waddr (store_waddr),
        .store_wdata (req.data_byte),
        .store_raddr (store_raddr),
        .len_waddr   (head_reg),
        .len_wdata   (len_val),
        .len_raddr   (tail_reg),
        .rd_byte     (rd_byte),
        .rd_len      (rd_len)
    );

    // limit in use, clamped to 1..SLOT_BYTES_MAX
    assign cfg_ext  = {1'b0, slot_bytes};
    assign lim_wide = (cfg_ext == 13'd0) ? 13'd1
                    : (cfg_ext > 13'(SLOT_BYTES_MAX)) ? 13'(SLOT_BYTES_MAX) : cfg_ext;
    assign limit    = POS_W'(lim_wide);

    // handshake and ring status
    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign ring_empty = (head_reg == tail_reg);
    assign pull_hit   = accept && (req.req_type == REQ_PULL) && !ring_empty;

    assign head_inc = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == SLOT_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
    assign wpos_inc = wpos_reg + 1'b1;
    assign rpos_inc = rpos_reg + 1'b1;

    // length recorded on the closing byte, which counts only when it is kept
    assign len_val = (wpos_reg < limit) ? wpos_inc : wpos_reg;

    // byte store addresses
    assign store_waddr = ADDR_W'(head_reg) * ADDR_W'(SLOT_BYTES_MAX) + ADDR_W'(wpos_reg);
    assign store_raddr = ADDR_W'(tail_reg) * ADDR_W'(SLOT_BYTES_MAX) + ADDR_W'(rpos_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pull_hit)
                begin
                    state_next = S_READ;
                end
                else if (accept && !out_free)
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                state_next = out_free ? S_IDLE : S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ring update and result word
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        drop_next = drop_reg;
        ovr_next  = ovr_reg;
        und_next  = und_reg;
        mem_ctl   = '0;
        res       = '0;
        res_ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.req_type == REQ_PUSH))
                begin
                    res_ready = 1'b1;
                    if (drop_reg)
                    begin
                        res.status = STAT_DROPPED;
                        if (req.last_in)
                        begin
                            drop_next = 1'b0;
                        end
                    end
                    else if ((wpos_reg == '0) && (head_inc == tail_reg))
                    begin
                        // ring full at a first byte: drop the whole frame
                        ovr_next   = ovr_reg + 32'd1;
                        res.status = STAT_DROPPED;
                        if (!req.last_in)
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (wpos_reg < limit)
                        begin
                            mem_ctl.store_we = 1'b1;
                            wpos_next        = wpos_inc;
                        end
                        else
                        begin
                            res.status = STAT_TRUNC;
                        end
                        if (req.last_in)
                        begin
                            mem_ctl.len_we = 1'b1;
                            head_next      = head_inc;
                            wpos_next      = '0;
                        end
                    end
                end
                else if (accept)
                begin
                    if (ring_empty)
                    begin
                        res_ready  = 1'b1;
                        und_next   = und_reg + 32'd1;
                        res.status = STAT_UNDERRUN;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                res_ready    = 1'b1;
                res.data_out = rd_byte;
                if ((rpos_inc >= rd_len) || (rpos_inc >= POS_W'(SLOT_BYTES_MAX)))
                begin
                    res.last_out = 1'b1;
                    tail_next    = tail_inc;
                    rpos_next    = '0;
                end
                else
                begin
                    rpos_next = rpos_inc;
                end
            end
            S_OUT:
            begin
                res_ready = 1'b0;
            end
            default:
            begin
                res_ready = 1'b0;
            end
        endcase

        // occupancy and counters after the step
        if (head_next >= tail_next)
        begin
            held_w = {1'b0, head_next} - {1'b0, tail_next};
        end
        else
        begin
            held_w = {1'b0, head_next} + (SLOT_W + 1)'(SLOTS) - {1'b0, tail_next};
        end
        held_x             = HW'(held_w);
        res.frames_held    = held_x[3:0];
        res.overrun_count  = ovr_next;
        res.underrun_count = und_next;
    end

    // output register and parked result
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_OUT)
        begin
            if (out_free)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
        end
        else if (res_ready)
        begin
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next = res;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            drop_reg      <= 1'b0;
            ovr_reg       <= '0;
            und_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            drop_reg      <= drop_next;
            ovr_reg       <= ovr_next;
            und_reg       <= und_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.data_out       = out_reg.data_out;
    assign rsp.last_out       = out_reg.last_out;
    assign rsp.status         = out_reg.status;
    assign rsp.frames_held    = out_reg.frames_held;
    assign rsp.overrun_count  = out_reg.overrun_count;
    assign rsp.underrun_count = out_reg.underrun_count;

    // checks
    `FRF_ASSERT(a_read_after_pull, clk, rst_n, state_reg == S_READ,
        $past(accept && (req.req_type == REQ_PULL)), "read cycle without an accepted pull")
    `FRF_ASSERT(a_park_needs_full_out, clk, rst_n, state_reg == S_OUT, out_valid_reg,
        "parked result while output register empty")
    `FRF_ASSERT_NEXT(a_park_holds, clk, rst_n, (state_reg == S_OUT) && !rsp.ready,
        state_reg == S_OUT, "parked result released while output stalled")
    `FRF_ASSERT(a_drop_at_frame_start, clk, rst_n, drop_reg, wpos_reg == '0,
        "dropping a frame with bytes already stored")

endmodule

// File: tb/frf_checker.sv
`timescale 1ns / 1ps
// result checker for the frame ring fifo: predicts each result word from the request words
// and the slot size writes it sees, and compares it with what the block returns
// depends on frf_pkg and the channel interfaces in frf_if
module frf_checker
    import frf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    frf_req_if                 req_mon,
    frf_rsp_if                 rsp_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen,
    output int                 frames_stored
);

    localparam int SLOTS     = SLOTS_DEF;
    localparam int BYTES_MAX = SLOT_BYTES_MAX_DEF;
    localparam logic [PADDR_W-1:0] SLOT_BYTES_ADDR = PADDR_W'(4 * int'(REG_SLOT_BYTES));

    // shadow copy of the ring
    bit [7:0]    byte_mem [SLOTS*BYTES_MAX];
    int unsigned frame_len [SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned wr_pos;
    int unsigned rd_pos;
    bit          discarding;
    bit [31:0]   drops_total;
    bit [31:0]   underruns_total;
    logic [11:0] byte_limit;

    rsp_t expected_q [$];
    rsp_t want;
    int   errors;
    int   checked;

    function automatic int unsigned next_of(input int unsigned s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    // advance the shadow ring by one request word and return the result it should give
    function automatic rsp_t predict_word(input logic kind, input logic [7:0] value,
                                          input logic tail_mark);
        rsp_t        r;
        int unsigned lim;
        r = '0;
        r.status = STAT_OK;
        lim = (byte_limit == 0) ? 1 : ((byte_limit > BYTES_MAX) ? BYTES_MAX : byte_limit);
        if (kind == REQ_PUSH)
        begin
            if (discarding)
            begin
                // rest of a frame that found the ring full
                r.status = STAT_DROPPED;
                if (tail_mark)
                    discarding = 1'b0;
            end
            else if (wr_pos == 0 && next_of(wr_slot) == rd_slot)
            begin
                drops_total = drops_total + 1;
                r.status = STAT_DROPPED;
                if (!tail_mark)
                    discarding = 1'b1;
            end
            else
            begin
                if (wr_pos < lim)
                begin
                    byte_mem[wr_slot*BYTES_MAX + wr_pos] = value;
                    wr_pos++;
                end
                else
                    r.status = STAT_TRUNC;
                // closing byte records the kept length
                if (tail_mark)
                begin
                    frame_len[wr_slot] = wr_pos;
                    wr_slot = next_of(wr_slot);
                    wr_pos = 0;
                end
            end
        end
        else
        begin
            if (wr_slot == rd_slot)
            begin
                underruns_total = underruns_total + 1;
                r.status = STAT_UNDERRUN;
            end
            else
            begin
                r.data_out = byte_mem[rd_slot*BYTES_MAX + rd_pos];
                rd_pos++;
                if (rd_pos >= frame_len[rd_slot] || rd_pos >= BYTES_MAX)
                begin
                    r.last_out = 1'b1;
                    rd_slot = next_of(rd_slot);
                    rd_pos = 0;
                end
            end
        end
        r.frames_held    = 4'((wr_slot + SLOTS - rd_slot) % SLOTS);
        r.overrun_count  = drops_total;
        r.underrun_count = underruns_total;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] frf_checker: %s", $realtime, msg);
        errors++;
    endtask

    // watch both channels and the config port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot         = 0;
            rd_slot         = 0;
            wr_pos          = 0;
            rd_pos          = 0;
            discarding      = 1'b0;
            drops_total     = '0;
            underruns_total = '0;
            byte_limit      = SLOT_BYTES_RST;
            errors          = 0;
            checked         = 0;
            expected_q.delete();
            fail_count    <= 0;
            pending       <= 0;
            results_seen  <= 0;
            frames_stored <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == SLOT_BYTES_ADDR)
                byte_limit = pwdata[11:0];

            // compare a returned word with the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request waiting",
                                              checked));
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_mon.data_out !== want.data_out)
                        report_mismatch($sformatf("result %0d data_out got %0h expected %0h",
                                                  checked, rsp_mon.data_out, want.data_out));
                    if (rsp_mon.last_out !== want.last_out)
                        report_mismatch($sformatf("result %0d last_out got %0b expected %0b",
                                                  checked, rsp_mon.last_out, want.last_out));
                    if (rsp_mon.status !== want.status)
                        report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                                  checked, rsp_mon.status, want.status));
                    if (rsp_mon.frames_held !== want.frames_held)
                        report_mismatch($sformatf("result %0d frames_held got %0d expected %0d",
                                                  checked, rsp_mon.frames_held,
                                                  want.frames_held));
                    if (rsp_mon.overrun_count !== want.overrun_count)
                        report_mismatch($sformatf("result %0d overrun_count got %0d expected %0d",
                                                  checked, rsp_mon.overrun_count,
                                                  want.overrun_count));
                    if (rsp_mon.underrun_count !== want.underrun_count)
                        report_mismatch($sformatf("result %0d underrun_count got %0d expected %0d",
                                                  checked, rsp_mon.underrun_count,
                                                  want.underrun_count));
                end
                checked++;
            end

            // predict the result of an accepted request word
            if (req_mon.valid && req_mon.ready)
                expected_q.push_back(predict_word(req_mon.req_type, req_mon.data_byte,
                                                  req_mon.last_in));

            fail_count    <= errors;
            pending       <= expected_q.size();
            results_seen  <= checked;
            frames_stored <= (wr_slot + SLOTS - rd_slot) % SLOTS;
        end
    end

endmodule

// File: tb/tb_frame_ring_fifo_core.sv
`timescale 1ns / 1ps
// testbench top for frame_ring_fifo_core: drives request words, result ready and the
// slot size register, and gives the verdict from the count kept by frf_checker
// depends on frf_pkg, frf_if, frf_checker and the block itself
module tb_frame_ring_fifo_core
    import frf_pkg::*;
();

    localparam int CLK_PERIOD     = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_PAUSE      = 8;
    localparam int PHASE_WORDS    = 500;
    localparam logic [PADDR_W-1:0] SLOT_BYTES_ADDR = PADDR_W'(4 * int'(REG_SLOT_BYTES));

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    frf_req_if req_ch ();
    frf_rsp_if rsp_ch ();

    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int cfg_writes;
    int stall_cycles;
    int fail_count;
    int pending;
    int results_seen;
    int frames_stored;

    frame_ring_fifo_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frf_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req_ch),
        .rsp_mon       (rsp_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .frames_stored (frames_stored)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // result ready with random stalls
    always @(posedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("** frame_ring_fifo_core: FAILED **");
                $finish;
            end
        end
    end

    // one request word, with an optional idle gap ahead of it
    task automatic send_word(input logic kind, input logic [7:0] value, input logic tail_mark);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.data_byte <= value;
        req_ch.last_in   <= tail_mark;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
    endtask

    // stop sending and wait until every result word is back
    task automatic drain_words();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_slot_bytes(input logic [11:0] value);
        drain_words();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLOT_BYTES_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    task automatic push_frame(input int len);
        for (int i = 0; i < len; i++)
            send_word(REQ_PUSH, 8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic pull_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_word(REQ_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    function automatic logic [11:0] pick_limit();
        case ($urandom_range(5))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd2048;
            3:       return 12'd4095;
            default: return 12'($urandom_range(2, 16));
        endcase
    endfunction

    // mostly whole frames and pull bursts, some ring-filling bursts and loose words
    task automatic run_traffic(input int goal);
        int target;
        int next_cfg;
        int pick;
        target   = words_sent + goal;
        next_cfg = words_sent + $urandom_range(80, 160);
        while (words_sent < target)
        begin
            if (words_sent >= next_cfg)
            begin
                write_slot_bytes(pick_limit());
                next_cfg = words_sent + $urandom_range(80, 160);
            end
            pick = $urandom_range(99);
            if (pick < 35)
                push_frame(($urandom_range(9) == 0) ? $urandom_range(13, 64)
                                                    : $urandom_range(1, 12));
            else if (pick < 75)
                pull_bytes($urandom_range(1, 32));
            else if (pick < 83)
            begin
                repeat ($urandom_range(14, 20))
                    push_frame($urandom_range(1, 3));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_PUSH;
        req_ch.data_byte <= 8'h00;
        req_ch.last_in   <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent    = 0;
        cfg_writes    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pull from an empty ring, then short frames with the byte extremes
        send_word(REQ_PULL, 8'h00, 1'b0);
        send_word(REQ_PUSH, 8'h00, 1'b1);
        send_word(REQ_PUSH, 8'hFF, 1'b0);
        send_word(REQ_PUSH, 8'h5A, 1'b1);
        send_word(REQ_PULL, 8'hFF, 1'b1);
        send_word(REQ_PULL, 8'h00, 1'b0);
        send_word(REQ_PULL, 8'h00, 1'b0);

        // truncation, with the last mark landing on a discarded byte
        write_slot_bytes(12'd2);
        send_word(REQ_PUSH, 8'h11, 1'b0);
        send_word(REQ_PUSH, 8'h22, 1'b0);
        send_word(REQ_PUSH, 8'h33, 1'b0);
        send_word(REQ_PUSH, 8'h44, 1'b1);

        // limit lowered mid-frame, pulls while that frame is still open
        send_word(REQ_PUSH, 8'h80, 1'b0);
        write_slot_bytes(12'd0);
        send_word(REQ_PULL, 8'h00, 1'b0);
        send_word(REQ_PULL, 8'h00, 1'b0);
        send_word(REQ_PUSH, 8'h81, 1'b1);
        send_word(REQ_PULL, 8'h00, 1'b0);
        send_word(REQ_PULL, 8'h00, 1'b0);

        // random traffic under three idle patterns
        write_slot_bytes(12'd4095);
        send_idle_pct = 37;
        recv_idle_pct = 73;
        run_traffic(PHASE_WORDS);
        send_idle_pct = 73;
        recv_idle_pct = 37;
        run_traffic(PHASE_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(PHASE_WORDS);

        // close any open frame and empty the ring
        send_word(REQ_PUSH, 8'hC3, 1'b1);
        drain_words();
        while (frames_stored != 0)
        begin
            pull_bytes(64);
            drain_words();
        end

        drain_words();
        repeat (END_PAUSE) @(posedge clk);
        $display("run covered %0d request words and %0d slot size writes (0 up to 4095)",
                 words_sent, cfg_writes);
        $display("%0d result words checked, ring fills, drops, truncation and underruns mixed in",
                 results_seen);
        if (fail_count == 0 && pending == 0)
            $display("** frame_ring_fifo_core: PASSED **");
        else
            $display("** frame_ring_fifo_core: FAILED **");
        $finish;
    end

endmodule
